// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by bba_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_GRANT = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_BAD   = 2'd2;

    // Datapath operations, executed only when the word's condition holds
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INC_T,
        OP_LOAD_LVL,
        OP_INC_LVL,
        OP_TAKE,
        OP_SPLIT
    } t_op;

    // Branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_BAD_SIZE,
        C_CEIL_MORE,
        C_SRCH_MISS,
        C_SRCH_MORE,
        C_SPLIT_MORE
    } t_cond;

    typedef logic [3:0] t_upc;

    // Program addresses
    localparam t_upc UA_CHECK = 4'd0;
    localparam t_upc UA_CEIL  = 4'd1;
    localparam t_upc UA_INIT  = 4'd2;
    localparam t_upc UA_MISS  = 4'd3;
    localparam t_upc UA_SRCH  = 4'd4;
    localparam t_upc UA_TAKE  = 4'd5;
    localparam t_upc UA_SPLIT = 4'd6;
    localparam t_upc UA_GRANT = 4'd7;
    localparam t_upc UA_FULL  = 4'd8;
    localparam t_upc UA_BAD   = 4'd9;

    typedef struct packed {
        t_cond   cond;
        t_op     op;
        t_upc    target;
        logic    emit;
        t_status status;
    } t_uword;

    // Condition flags from the datapath
    typedef struct packed {
        logic bad_size;
        logic ceil_more;
        logic srch_miss;
        logic srch_more;
        logic split_more;
    } t_flags;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic op_en;
        t_op  op;
    } t_dp_ctrl;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    function automatic t_uword uw(input t_cond c, input t_op o, input t_upc tgt,
                                  input logic e, input t_status s);
        t_uword w;
        w.cond   = c;
        w.op     = o;
        w.target = tgt;
        w.emit   = e;
        w.status = s;
        return w;
    endfunction

    // Control store: on a true condition run the op and jump, else fall through; emit words end the run
    function automatic t_uword ucode_word(input t_upc pc);
        t_uword w;
        case (pc)
            UA_CHECK: w = uw(C_BAD_SIZE,   OP_NOP,      UA_BAD,   1'b0, ST_GRANT);
            UA_CEIL:  w = uw(C_CEIL_MORE,  OP_INC_T,    UA_CEIL,  1'b0, ST_GRANT);
            UA_INIT:  w = uw(C_ALWAYS,     OP_LOAD_LVL, UA_MISS,  1'b0, ST_GRANT);
            UA_MISS:  w = uw(C_SRCH_MISS,  OP_NOP,      UA_FULL,  1'b0, ST_GRANT);
            UA_SRCH:  w = uw(C_SRCH_MORE,  OP_INC_LVL,  UA_MISS,  1'b0, ST_GRANT);
            UA_TAKE:  w = uw(C_ALWAYS,     OP_TAKE,     UA_SPLIT, 1'b0, ST_GRANT);
            UA_SPLIT: w = uw(C_SPLIT_MORE, OP_SPLIT,    UA_SPLIT, 1'b0, ST_GRANT);
            UA_GRANT: w = uw(C_ALWAYS,     OP_NOP,      UA_CHECK, 1'b1, ST_GRANT);
            UA_FULL:  w = uw(C_ALWAYS,     OP_NOP,      UA_CHECK, 1'b1, ST_FULL);
            UA_BAD:   w = uw(C_ALWAYS,     OP_NOP,      UA_CHECK, 1'b1, ST_BAD);
            default:  w = uw(C_ALWAYS,     OP_NOP,      UA_CHECK, 1'b1, ST_BAD);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/bba_dp.sv =====
module bba_dp #(
    parameter int LEVELS = 10,
    parameter int SW = LEVELS,
    parameter int AW = LEVELS - 1,
    parameter int LW = $clog2(LEVELS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_dp_ctrl i_ctrl,
    input  logic [SW-1:0]     i_size,
    output bba_pkg::t_flags   o_flags,
    output logic [AW-1:0]     o_start,
    output logic [LW-1:0]     o_level
);
    import bba_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);
    localparam logic [LW-1:0] TOP  = LW'(LEVELS - 1);
    localparam logic [SW-1:0] HEAP = SW'(1) << (LEVELS - 1);

    logic [SW-1:0]   r_size;
    logic [LW-1:0]   r_t;
    logic [CW-1:0]   r_lvl;
    logic [AW-1:0]   r_s;
    logic [LEVELS-1:0] r_valid;
    logic [AW-1:0]   r_fstart [LEVELS];

    logic [LW-1:0] lvl_idx;
    logic [CW-1:0] lvl_m1;
    logic [LW-1:0] lvl_m1_idx;
    logic [SW-1:0] one_t;
    logic          valid_at;
    logic [AW-1:0] half_ofs;

    assign lvl_idx    = r_lvl[LW-1:0];
    assign lvl_m1     = r_lvl - CW'(1);
    assign lvl_m1_idx = lvl_m1[LW-1:0];
    assign one_t      = SW'(1) << r_t;
    assign valid_at   = (r_lvl < CW'(LEVELS)) && r_valid[lvl_idx];
    assign half_ofs   = AW'(1) << lvl_m1;

    always_comb begin
        o_flags.bad_size   = (r_size == '0) || (r_size > HEAP);
        o_flags.ceil_more  = (r_t < TOP) && (one_t < r_size);
        o_flags.srch_miss  = (r_lvl == CW'(LEVELS));
        o_flags.srch_more  = !valid_at;
        o_flags.split_more = (r_lvl > CW'(r_t));
    end

    assign o_start = r_s;
    assign o_level = r_t;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_size <= i_size;
            r_t    <= '0;
        end else if (i_ctrl.op_en && i_ctrl.op == OP_INC_T) begin
            r_t <= r_t + LW'(1);
        end

        if (i_ctrl.op_en) begin
            case (i_ctrl.op)
                OP_LOAD_LVL: r_lvl <= CW'(r_t);
                OP_INC_LVL:  r_lvl <= r_lvl + CW'(1);
                OP_TAKE:     r_s   <= r_fstart[lvl_idx];
                OP_SPLIT:    r_lvl <= lvl_m1;
                default:     r_lvl <= r_lvl;
            endcase
        end
    end

    // Free-level table: one block per level at most
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= {1'b1, {(LEVELS-1){1'b0}}};
            for (int i = 0; i < LEVELS; i++) begin
                r_fstart[i] <= '0;
            end
        end else if (i_ctrl.op_en) begin
            case (i_ctrl.op)
                OP_TAKE: r_valid[lvl_idx] <= 1'b0;
                OP_SPLIT: begin
                    r_valid[lvl_m1_idx]  <= 1'b1;
                    r_fstart[lvl_m1_idx] <= r_s + half_ofs;
                end
                default: r_valid <= r_valid;
            endcase
        end
    end

endmodule

// ===== rtl/core/bba_seq.sv =====
module bba_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    input  bba_pkg::t_flags   i_flags,
    output logic              o_idle,
    output bba_pkg::t_dp_ctrl o_ctrl,
    output logic              o_emit,
    output bba_pkg::t_status  o_status
);
    import bba_pkg::*;

    t_seq_state r_state, n_state;
    t_upc       r_pc, n_pc;
    t_uword     word;
    logic       cond_true;
    logic       emit_fire;

    assign word = ucode_word(r_pc);

    always_comb begin
        case (word.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_BAD_SIZE:   cond_true = i_flags.bad_size;
            C_CEIL_MORE:  cond_true = i_flags.ceil_more;
            C_SRCH_MISS:  cond_true = i_flags.srch_miss;
            C_SRCH_MORE:  cond_true = i_flags.srch_more;
            C_SPLIT_MORE: cond_true = i_flags.split_more;
            default:      cond_true = 1'b0;
        endcase
    end

    assign emit_fire = (r_state == SEQ_RUN) && word.emit && i_out_free;

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_pc    = UA_CHECK;
                end
            end
            SEQ_RUN: begin
                if (word.emit) begin
                    if (i_out_free) begin
                        n_state = SEQ_IDLE;
                    end
                end else if (cond_true) begin
                    n_pc = word.target;
                end else begin
                    n_pc = r_pc + t_upc'(1);
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_idle       = (r_state == SEQ_IDLE);
        o_ctrl.load  = (r_state == SEQ_IDLE) && i_start;
        o_ctrl.op_en = (r_state == SEQ_RUN) && !word.emit && cond_true;
        o_ctrl.op    = word.op;
        o_emit       = emit_fire;
        o_status     = word.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_pc    <= UA_CHECK;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// Buddy allocator, allocation only. One word in flight at a time.
// Each word runs a single microcoded loop, one step per cycle: round the request up
// to a level t, search upward for a free level g and split it down to t. An invalid
// size or a heap with no free block ends the word early with a reject status. The
// loop holds on its result step while the output register is still full.
// Synchronous active-low reset: only the top level is free, output register empty.
module buddy_block_allocator #(
    parameter int LEVELS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [LEVELS-1:0]           i_request_size,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bba_pkg::t_status            o_status,
    output logic [LEVELS-2:0]           o_block_start,
    output logic [$clog2(LEVELS)-1:0]   o_block_level
);
    import bba_pkg::*;

    localparam int SW = LEVELS;
    localparam int AW = LEVELS - 1;
    localparam int LW = $clog2(LEVELS);

    t_dp_ctrl      dp_ctrl;
    t_flags        flags;
    logic          seq_idle;
    logic          emit;
    t_status       emit_status;
    logic          out_free;
    logic [AW-1:0] dp_start;
    logic [LW-1:0] dp_level;

    logic          r_out_valid;
    t_status       r_status;
    logic [AW-1:0] r_start;
    logic [LW-1:0] r_level;

    // Take a new word only when the sequencer is idle; the output register
    // lets it run on while a finished result still waits downstream.
    assign o_ready  = seq_idle;
    assign out_free = !r_out_valid || i_ready;

    bba_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_idle     (seq_idle),
        .o_ctrl     (dp_ctrl),
        .o_emit     (emit),
        .o_status   (emit_status)
    );

    bba_dp #(
        .LEVELS (LEVELS),
        .SW     (SW),
        .AW     (AW),
        .LW     (LW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dp_ctrl),
        .i_size  (i_request_size),
        .o_flags (flags),
        .o_start (dp_start),
        .o_level (dp_level)
    );

    // Output register: load on emit, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Zero start and level unless granted
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= emit_status;
            r_start  <= (emit_status == ST_GRANT) ? dp_start : '0;
            r_level  <= (emit_status == ST_GRANT) ? dp_level : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_block_start = r_start;
    assign o_block_level = r_level;

endmodule

// ===== rtl/core/bba_checker.sv =====
`include "assert_macros.svh"

module bba_checker #(
    parameter int LEVELS = 10
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic [LEVELS-1:0]         i_request_size,
    input logic                      o_valid,
    input logic                      i_ready,
    input bba_pkg::t_status          o_status,
    input logic [LEVELS-2:0]         o_block_start,
    input logic [$clog2(LEVELS)-1:0] o_block_level
);
    import bba_pkg::*;

    localparam int AW = LEVELS - 1;

    logic [AW-1:0] low_mask;
    logic          req_seen;

    assign low_mask = ~({AW{1'b1}} << o_block_level);
    assign req_seen = (i_request_size == i_request_size);

    `ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_valid && req_seen,
        o_status == ST_GRANT || o_status == ST_FULL || o_status == ST_BAD)

    `ASSERT_NOW(a_zero_on_reject, i_clk, i_rst_n, o_valid && o_status != ST_GRANT,
        o_block_start == '0 && o_block_level == '0)

    `ASSERT_NOW(a_grant_aligned, i_clk, i_rst_n, o_valid && o_status == ST_GRANT,
        (o_block_start & low_mask) == '0)

    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    `ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_status) && $stable(o_block_start) && $stable(o_block_level))

endmodule

bind buddy_block_allocator bba_checker #(.LEVELS(LEVELS)) u_bba_checker (.*);

// ===== sim/buddy_block_allocator_tb.sv =====
`timescale 1ns / 100ps

module buddy_block_allocator_tb;

    import bba_pkg::*;

    localparam int HEAP_LEVELS = 10;
    localparam int TOP_LEVEL   = HEAP_LEVELS - 1;
    localparam int HEAP_UNITS  = 1 << TOP_LEVEL;
    localparam int RANDOM_WORDS = 450;
    // Allow for the slowest word plus sender gaps and receiver stalls,
    // then take the whole thing several times over.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;

    // One allocation outcome as the block reports it
    typedef struct packed {
        t_status    status;
        logic [8:0] start;
        logic [3:0] level;
    } t_alloc_outcome;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [9:0] i_request_size;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_status    o_status;
    logic [8:0] o_block_start;
    logic [3:0] o_block_level;

    // Free list mirror: with nothing ever freed, each level holds at most one block
    logic       level_avail [HEAP_LEVELS];
    logic [8:0] level_base  [HEAP_LEVELS];

    t_alloc_outcome alloc_outcomes[$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             burst_left = 0;

    buddy_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_request_size (i_request_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_block_start  (o_block_start),
        .o_block_level  (o_block_level)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run; a hung handshake lands here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Allocator prediction
    // ------------------------------------------------------------------

    // Clear the mirror to the reset picture: only the whole heap is free.
    function automatic void clear_free_list();
        for (int i = 0; i < HEAP_LEVELS; i++) begin
            level_avail[i] = 1'b0;
            level_base[i]  = '0;
        end
        level_avail[TOP_LEVEL] = 1'b1;
    endfunction

    // Round the request up to a level, take the smallest free block at or above it,
    // split it down and release each upper half on the way.
    function automatic t_alloc_outcome allocate_block(input logic [9:0] size);
        t_alloc_outcome res;
        int             want_lvl;
        int             found;
        logic [8:0]     base;
        res = '{status: ST_GRANT, start: '0, level: '0};
        if (size == 0 || size > HEAP_UNITS) begin
            res.status = ST_BAD;
            return res;
        end
        want_lvl = 0;
        while (want_lvl < TOP_LEVEL && (1 << want_lvl) < size)
            want_lvl++;
        found = want_lvl;
        while (found < HEAP_LEVELS && !level_avail[found])
            found++;
        if (found >= HEAP_LEVELS) begin
            res.status = ST_FULL;
            return res;
        end
        base = level_base[found];
        level_avail[found] = 1'b0;
        for (int l = found; l > want_lvl; l--) begin
            level_avail[l-1] = 1'b1;
            level_base[l-1]  = base + 9'(1 << (l - 1));
        end
        res.start = base;
        res.level = 4'(want_lvl);
        return res;
    endfunction

    // Highest level that still holds a free block, or -1 once the heap is used up
    function automatic int highest_free();
        for (int l = TOP_LEVEL; l >= 0; l--)
            if (level_avail[l])
                return l;
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Sender and receiver
    // ------------------------------------------------------------------

    // Present one request word, hold it until accepted, then predict its outcome.
    // Words go out in bursts; a burst ending drops valid for a random gap.
    task automatic send_request(input logic [9:0] size);
        int gap;
        i_valid        <= 1'b1;
        i_request_size <= size;
        do @(posedge i_clk); while (!o_ready);
        alloc_outcomes.push_back(allocate_block(size));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            // Long bursts give stretches with no sender idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver stalls follow a randomly redrawn mode: always ready, coin flip or a sparse periodic pattern
    int unsigned stall_mode = 0;
    int unsigned stall_tick = 0;
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 48 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_ready <= (stall_tick % 4 == 0);
            end
            default: begin
                i_ready <= (stall_tick % 8 == 3);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Compare each result word against the oldest outstanding prediction
    always @(posedge i_clk) begin
        t_alloc_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (alloc_outcomes.size() == 0) begin
                report_mismatch($sformatf("unrequested result: status %0d start %0d level %0d",
                                          o_status, o_block_start, o_block_level));
            end else begin
                want = alloc_outcomes.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_block_start !== want.start)
                    report_mismatch($sformatf("block_start %0d, want %0d",
                                              o_block_start, want.start));
                if (o_block_level !== want.level)
                    report_mismatch($sformatf("block_level %0d, want %0d",
                                              o_block_level, want.level));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero and oversize requests: flag them and leave the heap alone
    task automatic test_invalid_sizes();
        send_request(10'd0);
        send_request(10'd1023);
        send_request(10'd513);
        send_request(10'd768);
    endtask

    // Small grants first so the opening word splits the whole heap down to one unit;
    // then a mix of exact powers of two and sizes that must round up to the next one.
    task automatic test_rounding();
        send_request(10'd1);
        send_request(10'd1);
        send_request(10'd3);
        send_request(10'd2);
        send_request(10'd5);
        send_request(10'd8);
        send_request(10'd9);
        send_request(10'd17);
        send_request(10'd33);
        send_request(10'd65);
        send_request(10'd4);
    endtask

    // Draw a request size: mostly tiny so the heap lasts, some larger, some invalid
    function automatic logic [9:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 10'd0;
        if (roll < 10)
            return 10'($urandom_range(HEAP_UNITS + 1, 1023));
        if (roll < 72)
            return 10'($urandom_range(1, 2));
        if (roll < 88)
            return 10'($urandom_range(3, 8));
        if (roll < 97)
            return 10'($urandom_range(9, 64));
        return 10'($urandom_range(65, HEAP_UNITS));
    endfunction

    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_WORDS; n++)
            send_request(pick_size());
    endtask

    // Take the largest free block until none is left, then confirm the heap reports full and zero is still bad
    task automatic test_exhaustion();
        int lvl;
        lvl = highest_free();
        while (lvl >= 0) begin
            send_request(10'(1 << lvl));
            lvl = highest_free();
        end
        send_request(10'd1);
        send_request(10'd512);
        send_request(10'd300);
        send_request(10'd0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_request_size <= '0;
        clear_free_list();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_invalid_sizes();
        test_rounding();
        test_random_mix();
        test_exhaustion();

        // Drop valid, drain outstanding results, then give the block time to misbehave
        i_valid <= 1'b0;
        while (alloc_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bba_pkg.sv
rtl/core/bba_dp.sv
rtl/core/bba_seq.sv
rtl/core/buddy_block_allocator.sv
rtl/core/bba_checker.sv
sim/buddy_block_allocator_tb.sv
